/* rtl/hrv_rmssd_nn50_window_unit_assert.svh */
// Assertion macros shared by the window unit.
`ifndef HRV_RMSSD_NN50_WINDOW_UNIT_ASSERT_SVH
`define HRV_RMSSD_NN50_WINDOW_UNIT_ASSERT_SVH
`ifndef SYNTH
`define HRV_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HRV_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define HRV_ASSERT_IMPL(label, clk, rst, prop, msg)
`define HRV_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

/* rtl/hrv_pkg.sv */
// Shared types and constants of the window unit.
package hrv_pkg;
   localparam int unsigned RateW = 16;
   localparam int unsigned IvlW = 24;
   localparam int unsigned SumW = 64;
   localparam int unsigned StepW = 12;
   localparam int unsigned SampW = 13;
   localparam logic [32:0] IntervalNum = 33'd6000000000;
   localparam logic [IvlW-1:0] IvlMax = '1;
   localparam logic [IvlW-1:0] ThreshReset = 24'd50000;

   typedef struct packed {
      logic [RateW-1:0] rate;
      logic             last;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_MUL, ST_ACC, ST_MEAN, ST_SQRT, ST_OUT
   } back_state_type;
endpackage

/* rtl/hrv_rmssd_nn50_window_unit.sv */
// Top level of the RMSSD and step-count window unit.
// Channel | Direction | tdata / tuser
// req     | in        | tdata[15:0] heart_rate, tlast last
// rsp     | out       | tdata[23:0] rmssd_us, [35:24] step_count, [48:36] sample_count,
//         |           | [49] overflow, [55:50] zero
// csr     | in        | wdata[23:0] step_threshold_us
// In the back end a sample runs through the serial interval divider, then the squared
// difference and accumulation, which the first sample of a window skips. A sample past
// the window limit is not counted and sets the overflow flag. The last sample adds mean
// division, square root and a load of the result, which waits while an earlier one is not yet taken.
// Reset clears the window; the threshold returns to 50000 us.
// A two-entry queue lets the input side accept while the back end works.
module hrv_rmssd_nn50_window_unit #(
   parameter int unsigned WINDOW_MAX = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // heart_rate
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // rmssd_us, step_count, sample_count, overflow
   input  logic        csr_we,
   input  logic [23:0] csr_wdata    // step_threshold_us
);
   import hrv_pkg::*;

   `include "hrv_rmssd_nn50_window_unit_assert.svh"

   logic [IvlW-1:0] thresh_ff, thresh_in;
   item_type in_item, q_item;
   logic q_valid, q_ready;
   logic [IvlW-1:0] rmssd;
   logic [StepW-1:0] steps;
   logic [SampW-1:0] samples;
   logic ovf;

   assign thresh_in = csr_we ? csr_wdata : thresh_ff;
   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= ThreshReset;
      else       thresh_ff <= thresh_in;
   end

   assign in_item.rate = req_tdata;
   assign in_item.last = req_tlast;

   hrv_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   hrv_back #(.WindowMax(WINDOW_MAX)) u_back (
      .clock(clock), .reset(reset), .thresh(thresh_ff), .q_valid(q_valid),
      .q_ready(q_ready), .q_item(q_item), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_rmssd(rmssd), .out_steps(steps),
      .out_samples(samples), .out_ovf(ovf)
   );

   assign rsp_tdata = {6'd0, ovf, samples, steps, rmssd};

   `HRV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `HRV_ASSERT_IMPL(a_cnt_ok, clock, reset, u_front.cnt_ff != 2'd3, "queue count out of range")
   `HRV_ASSERT_NEXT(a_full_stall, clock, reset, !req_tready && !q_ready, !req_tready, "full queue")
endmodule

/* rtl/hrv_front.sv */
// Input stage and two-entry queue feeding the back end.
module hrv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hrv_pkg::item_type    in_item,
   output logic                 q_valid,
   input  logic                 q_ready,
   output hrv_pkg::item_type    q_item
);
   import hrv_pkg::*;

   item_type   mem_ff [2];
   item_type   mem_in0, mem_in1;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in   = push ? ~wp_ff : wp_ff;
      rp_in   = pop ? ~rp_ff : rp_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      mem_in0 = (push && !wp_ff) ? in_item : mem_ff[0];
      mem_in1 = (push && wp_ff) ? in_item : mem_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      mem_ff[0] <= mem_in0;
      mem_ff[1] <= mem_in1;
   end
endmodule

/* rtl/hrv_back.sv */
// Back end: serial divider, squared difference, accumulation, mean division and square root.
module hrv_back #(
   parameter int unsigned WindowMax = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hrv_pkg::IvlW-1:0]      thresh,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  hrv_pkg::item_type             q_item,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [hrv_pkg::IvlW-1:0]      out_rmssd,
   output logic [hrv_pkg::StepW-1:0]     out_steps,
   output logic [hrv_pkg::SampW-1:0]     out_samples,
   output logic                          out_ovf
);
   import hrv_pkg::*;

   localparam int unsigned CntW = $clog2(WindowMax + 1) + 1;

   back_state_type st_ff, st_in;
   logic [6:0]   it_ff, it_in;
   logic         last_ff, last_in;
   logic [15:0]  rate_ff, rate_in;
   logic [32:0]  quo_ff, quo_in;
   logic [16:0]  rem_ff, rem_in;
   logic [IvlW-1:0] diff_ff, diff_in;
   logic [47:0]  sq_ff, sq_in;
   logic [IvlW-1:0] prev_ff, prev_in;
   logic         havep_ff, havep_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic [StepW-1:0] steps_ff, steps_in;
   logic [CntW-1:0] samp_ff, samp_in;
   logic         ovf_ff, ovf_in;
   // Mean divider (64 by CntW) and square-root shared registers.
   logic [SumW-1:0] num_ff, num_in;
   logic [CntW:0]   mrem_ff, mrem_in;
   logic [SumW-1:0] rad_ff, rad_in;
   logic [33:0]     rt_ff, rt_in;
   logic [35:0]     srem_ff, srem_in;
   logic            ov_ff, ov_in;
   logic [IvlW-1:0] o_rmssd_ff, o_rmssd_in;
   logic [StepW-1:0] o_steps_ff, o_steps_in;
   logic [SampW-1:0] o_samp_ff, o_samp_in;
   logic         o_ovf_ff, o_ovf_in;

   logic [16:0]  rtrial;
   logic [CntW:0] mtrial;
   logic [CntW-1:0] dvs;
   logic [35:0]  strial;
   logic [IvlW-1:0] ivl;
   logic [SumW:0] sumx;

   assign out_valid   = ov_ff;
   assign out_rmssd   = o_rmssd_ff;
   assign out_steps   = o_steps_ff;
   assign out_samples = o_samp_ff;
   assign out_ovf     = o_ovf_ff;
   assign q_ready     = (st_ff == ST_IDLE);

   always_comb begin
      st_in = st_ff; it_in = it_ff; last_in = last_ff; rate_in = rate_ff;
      quo_in = quo_ff; rem_in = rem_ff; diff_in = diff_ff; sq_in = sq_ff;
      prev_in = prev_ff; havep_in = havep_ff; sum_in = sum_ff;
      steps_in = steps_ff; samp_in = samp_ff; ovf_in = ovf_ff;
      num_in = num_ff; mrem_in = mrem_ff; rad_in = rad_ff; rt_in = rt_ff;
      srem_in = srem_ff; ov_in = ov_ff;
      o_rmssd_in = o_rmssd_ff; o_steps_in = o_steps_ff;
      o_samp_in = o_samp_ff; o_ovf_in = o_ovf_ff;
      rtrial = {rem_ff[15:0], quo_ff[32]};
      dvs    = samp_ff - CntW'(1);
      mtrial = {mrem_ff[CntW-1:0], num_ff[SumW-1]};
      strial = {srem_ff[33:0], rad_ff[SumW-1 -: 2]};
      ivl    = (rate_ff == 16'd0 || quo_ff[32:IvlW] != '0) ? IvlMax : quo_ff[IvlW-1:0];
      sumx   = {1'b0, sum_ff} + {17'd0, sq_ff};
      if (out_ready) ov_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               rate_in = q_item.rate;
               last_in = q_item.last;
               quo_in  = IntervalNum;
               rem_in  = '0;
               it_in   = '0;
               if (samp_ff < CntW'(WindowMax)) st_in = ST_DIV;
               else begin
                  ovf_in = 1'b1;
                  st_in  = q_item.last ? ST_MEAN : ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (rtrial >= {1'b0, rate_ff}) begin
               rem_in = rtrial - {1'b0, rate_ff};
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = rtrial;
               quo_in = {quo_ff[31:0], 1'b0};
            end
            it_in = it_ff + 7'd1;
            if (it_ff == 7'd32) st_in = ST_MUL;
         end
         ST_MUL: begin
            diff_in = (ivl >= prev_ff) ? ivl - prev_ff : prev_ff - ivl;
            st_in   = havep_ff ? ST_ACC : ST_MEAN;
            if (!havep_ff) begin
               prev_in = ivl; havep_in = 1'b1; samp_in = samp_ff + CntW'(1);
               st_in   = last_ff ? ST_MEAN : ST_IDLE;
            end
            sq_in = '0;
            it_in = '0;
         end
         ST_ACC: begin
            if (it_ff == '0) begin
               sq_in = 48'(diff_ff) * 48'(diff_ff);
               it_in = 7'd1;
            end else begin
               sum_in = sumx[SumW] ? '1 : sumx[SumW-1:0];
               if (diff_ff > thresh && steps_ff != '1) steps_in = steps_ff + StepW'(1);
               prev_in = ivl; samp_in = samp_ff + CntW'(1);
               it_in   = '0;
               st_in   = last_ff ? ST_MEAN : ST_IDLE;
            end
         end
         ST_MEAN: begin
            // Runs the mean division of the sum by the sample count minus one; under two samples the radicand is zero.
            if (samp_ff < CntW'(2)) begin
               rad_in = '0; it_in = 7'd0; rt_in = '0; srem_in = '0;
               st_in  = ST_SQRT;
            end else begin
               if (it_ff == 7'd0) begin
                  num_in = sum_ff; mrem_in = '0; it_in = 7'd1;
               end else begin
                  if (mtrial >= {1'b0, dvs}) begin
                     mrem_in = mtrial - {1'b0, dvs};
                     num_in  = {num_ff[SumW-2:0], 1'b1};
                  end else begin
                     mrem_in = mtrial;
                     num_in  = {num_ff[SumW-2:0], 1'b0};
                  end
                  it_in = it_ff + 7'd1;
                  if (it_ff == 7'd64) begin
                     rad_in = {num_ff[SumW-2:0], (mtrial >= {1'b0, dvs})};
                     it_in = '0; rt_in = '0; srem_in = '0;
                     st_in = ST_SQRT;
                  end
               end
            end
         end
         ST_SQRT: begin
            // Two radicand bits per cycle.
            if (strial >= {rt_ff, 2'b01}) begin
               srem_in = strial - {rt_ff, 2'b01};
               rt_in   = {rt_ff[32:0], 1'b1};
            end else begin
               srem_in = strial;
               rt_in   = {rt_ff[32:0], 1'b0};
            end
            rad_in = {rad_ff[SumW-3:0], 2'b00};
            it_in  = it_ff + 7'd1;
            if (it_ff == 7'd31) st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ov_ff || out_ready) begin
               ov_in      = 1'b1;
               o_rmssd_in = (rt_ff[33:IvlW] != '0) ? IvlMax : rt_ff[IvlW-1:0];
               o_steps_in = steps_ff;
               o_samp_in  = (samp_ff > CntW'(8191)) ? 13'h1FFF : SampW'(samp_ff);
               o_ovf_in   = ovf_ff;
               prev_in = '0; havep_in = 1'b0; sum_in = '0; steps_in = '0;
               samp_in = '0; ovf_in = 1'b0; it_in = '0;
               st_in   = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; it_ff <= '0; prev_ff <= '0; havep_ff <= 1'b0;
         sum_ff <= '0; steps_ff <= '0; samp_ff <= '0; ovf_ff <= 1'b0;
         ov_ff <= 1'b0; mrem_ff <= '0;
      end else begin
         st_ff <= st_in; it_ff <= it_in; prev_ff <= prev_in; havep_ff <= havep_in;
         sum_ff <= sum_in; steps_ff <= steps_in; samp_ff <= samp_in;
         ovf_ff <= ovf_in; ov_ff <= ov_in; mrem_ff <= mrem_in;
      end
      last_ff <= last_in; rate_ff <= rate_in; quo_ff <= quo_in; rem_ff <= rem_in;
      diff_ff <= diff_in; sq_ff <= sq_in; num_ff <= num_in; rad_ff <= rad_in;
      rt_ff <= rt_in; srem_ff <= srem_in;
      o_rmssd_ff <= o_rmssd_in; o_steps_ff <= o_steps_in;
      o_samp_ff <= o_samp_in; o_ovf_ff <= o_ovf_in;
   end
endmodule

/* verif/hrv_rmssd_nn50_window_unit_tb.sv */
// Self-checking bench for the RMSSD and step-count window unit.
`timescale 1ns / 1ps

module hrv_rmssd_nn50_window_unit_tb;
   import hrv_pkg::*;

   localparam int unsigned WinMax = 4096;
   localparam longint unsigned CycleLimit = 4000000;

   typedef struct packed {
      logic        overflow;
      logic [12:0] sample_count;
      logic [11:0] step_count;
      logic [23:0] rmssd_us;
   } window_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [23:0] csr_wdata = '0;

   // Predictor state.
   logic [23:0]     threshold_us;
   logic [23:0]     prev_ivl;
   logic            have_prev;
   longint unsigned sq_sum;
   int unsigned     steps;
   int unsigned     samples;
   logic            win_ovf;

   window_result_type pending_windows[$];
   int unsigned     error_count = 0;
   int unsigned     windows_checked = 0;
   int unsigned     items_sent = 0;
   longint unsigned cycle_count = 0;
   bit              long_hold = 1'b0;
   int unsigned     gap_max = 3;

   hrv_rmssd_nn50_window_unit #(.WINDOW_MAX(WinMax)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("hrv_rmssd_nn50_window_unit_tb failed");
         $finish;
      end
   end

   function automatic logic [23:0] beat_interval(input logic [15:0] rate);
      longint unsigned q;
      if (rate == 0) return IvlMax;
      q = 64'd6000000000 / rate;
      return (q > 64'hFFFFFF) ? IvlMax : q[23:0];
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'hFFFFFFFF;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   task automatic clear_window_model();
      prev_ivl = '0;
      have_prev = 1'b0;
      sq_sum = 0;
      steps = 0;
      samples = 0;
      win_ovf = 1'b0;
   endtask

   task automatic predict_window(input logic [15:0] rate, input logic last);
      logic [23:0]     ivl, diff;
      longint unsigned sq, root;
      window_result_type r;
      if (samples < WinMax) begin
         ivl = beat_interval(rate);
         if (have_prev) begin
            diff = (ivl >= prev_ivl) ? ivl - prev_ivl : prev_ivl - ivl;
            sq = longint'(diff) * longint'(diff);
            sq_sum = (sq_sum > ~64'd0 - sq) ? ~64'd0 : sq_sum + sq;
            if (diff > threshold_us && steps < 4095) steps++;
         end
         prev_ivl = ivl;
         have_prev = 1'b1;
         samples++;
      end else begin
         win_ovf = 1'b1;
      end
      if (last) begin
         root = (samples >= 2) ? floor_sqrt(sq_sum / (samples - 1)) : 0;
         if (root > 64'hFFFFFF) root = 64'hFFFFFF;
         r.rmssd_us = root[23:0];
         r.step_count = steps[11:0];
         r.sample_count = (samples > 8191) ? 13'd8191 : samples[12:0];
         r.overflow = win_ovf;
         pending_windows.push_back(r);
         clear_window_model();
      end
   endtask

   // Sends one sample; random gaps before it give the sender its bursts.
   task automatic send_sample(input logic [15:0] rate, input logic last);
      if ($urandom_range(3, 0) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(gap_max, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= rate;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_window(rate, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_windows.size() != 0) @(negedge clock);
      // A trailing non-last sample may still be inside the divider.
      repeat (200) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [23:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      threshold_us = value;
   endtask

   function automatic logic [15:0] random_rate();
      case ($urandom_range(9, 0))
         0: return 16'($urandom_range(65535, 0));
         1: return 16'($urandom_range(400, 0));
         default: return 16'($urandom_range(12000, 4000));
      endcase
   endfunction

   task automatic test_directed();
      send_sample(16'd0, 1'b1);
      send_sample(16'd6000, 1'b0);
      send_sample(16'd6000, 1'b1);
      send_sample(16'd0, 1'b0);
      send_sample(16'd65535, 1'b0);
      send_sample(16'd1, 1'b0);
      send_sample(16'd357, 1'b0);
      send_sample(16'd358, 1'b0);
      send_sample(16'd7000, 1'b0);
      send_sample(16'd7500, 1'b1);
      send_sample(16'hAAAA, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hFFFF, 1'b1);
   endtask

   task automatic test_threshold_extremes();
      write_threshold(24'd0);
      for (int i = 0; i < 6; i++) send_sample(random_rate(), i == 5);
      write_threshold(24'hFFFFFF);
      for (int i = 0; i < 6; i++) send_sample(random_rate(), i == 5);
      write_threshold(24'd1000);
      for (int i = 0; i < 5; i++) send_sample(16'(6000 + 100 * i), i == 4);
   endtask

   task automatic test_random_windows();
      int unsigned len;
      for (int w = 0; items_sent < 850; w++) begin
         if (w % 40 == 20) write_threshold(24'($urandom_range(200000, 0)));
         len = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 2);
         for (int i = 0; i < len; i++) send_sample(random_rate(), i == len - 1);
      end
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      for (int i = 0; i < 12; i++) send_sample(random_rate(), (i % 2) == 1);
      long_hold = 1'b0;
   endtask

   // Receiver: random stall pattern, quiet stretches, and one long hold-off.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (long_hold) rsp_tready <= 1'b0;
      else if ((cycle_count / 512) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(3, 0) != 0);
   end

   always @(posedge clock) begin
      window_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = window_result_type'(rsp_tdata[49:0]);
         if (pending_windows.size() == 0) begin
            $error("result transaction with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_windows.pop_front();
            windows_checked++;
            if (got.rmssd_us !== want.rmssd_us) begin
               $error("rmssd_us expected %0d got %0d", want.rmssd_us, got.rmssd_us);
               error_count++;
            end
            if (got.step_count !== want.step_count) begin
               $error("step_count expected %0d got %0d", want.step_count, got.step_count);
               error_count++;
            end
            if (got.sample_count !== want.sample_count) begin
               $error("sample_count expected %0d got %0d",
                      want.sample_count, got.sample_count);
               error_count++;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow expected %0d got %0d", want.overflow, got.overflow);
               error_count++;
            end
         end
      end
   end

   initial begin
      threshold_us = ThreshReset;
      clear_window_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_threshold_extremes();
      write_threshold(24'd50000);
      test_random_windows();
      wait_drained();
      $display("Sent %0d samples, checked %0d windows, incl. threshold extremes and stalls.",
               items_sent, windows_checked);
      if (error_count == 0 && pending_windows.size() == 0)
         $display("hrv_rmssd_nn50_window_unit_tb passed");
      else
         $display("hrv_rmssd_nn50_window_unit_tb failed");
      $finish;
   end

   // Long receiver hold-off while the sender keeps offering samples.
   initial begin
      wait (long_hold);
      repeat (600) @(negedge clock);
      long_hold = 1'b0;
   end
endmodule
